FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk, and not while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, during reset too.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/udscan_pkg.sv
// ----------------------------------------------------------------------------
// udscan_pkg
// Types, constants and the digit decoder shared by the counter and scan logic.
// ----------------------------------------------------------------------------
package udscan_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_UP   = 2'd1,
    OP_DOWN = 2'd2,
    OP_LOAD = 2'd3
  } opcode_t;

  localparam int unsigned CountW  = 10;
  localparam int unsigned SegW    = 7;
  localparam int unsigned PosW    = 2;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned ByteW   = 8;

  localparam logic [CountW-1:0] CountMax = 10'd999;

  localparam logic [PosW-1:0] PosHundreds = 2'd0;
  localparam logic [PosW-1:0] PosTens     = 2'd1;
  localparam logic [PosW-1:0] PosUnits    = 2'd2;

  // Reciprocal multipliers: x*41 >> 12 is x/100 and x*103 >> 10 is x/10
  // over the ranges used here (count up to 999, remainder up to 99).
  localparam logic [5:0] RecipHundred = 6'd41;
  localparam int unsigned RecipHundredShift = 12;
  localparam logic [6:0] RecipTen = 7'd103;
  localparam int unsigned RecipTenShift = 10;

  // Decimal digit to gfedcba pattern; bit 0 is segment a.
  function automatic logic [SegW-1:0] seg_decode(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] seg;
    unique case (digit)
      4'd0:    seg = 7'b0111111;
      4'd1:    seg = 7'b0000110;
      4'd2:    seg = 7'b1011011;
      4'd3:    seg = 7'b1001111;
      4'd4:    seg = 7'b1100110;
      4'd5:    seg = 7'b1101101;
      4'd6:    seg = 7'b1111101;
      4'd7:    seg = 7'b0000111;
      4'd8:    seg = 7'b1111111;
      default: seg = 7'b1101111;
    endcase
    return seg;
  endfunction

endpackage

FILE: hw/rtl/updown_counter_seven_segment_scan_core.sv
// ----------------------------------------------------------------------------
// updown_counter_seven_segment_scan_core
// Decimal up/down counter (0 to 999) driving a three-digit multiplexed
// seven-segment display. Each request steps the count up or down, loads a
// byte into it, or advances the display scan by one digit (hundreds, tens,
// units). The count saturates at 0 and 999. Every request yields one result
// carrying the shown pattern, the enabled digit and the count. The block takes
// one request per cycle while its second output slot is empty. A result is
// registered in the output register, or in the second slot while a result
// there is held by stall. Requests stall only when both slots are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module updown_counter_seven_segment_scan_core (
  input  logic       clk,
  input  logic       rst,

  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] load_value,

  output logic       res_valid,
  input  logic       res_stall,
  output logic [6:0] segments,
  output logic [1:0] digit_index,
  output logic [9:0] count_value
);

  // Architectural state.
  logic [9:0] count;
  logic [9:0] count_next;
  logic [1:0] scan_pos;
  logic [1:0] scan_pos_next;
  logic [6:0] shown;
  logic [6:0] shown_next;
  logic [1:0] enabled_next;

  // Second output slot.
  logic       skid_valid;
  logic [6:0] skid_segments;
  logic [1:0] skid_digit_index;
  logic [9:0] skid_count_value;

  logic       cmd_take;
  logic       res_take;

  // Digit extraction.
  logic [15:0] hund_prod;
  logic [3:0]  hund_digit;
  logic [9:0]  hund_scaled;
  logic [6:0]  rem_hund;
  logic [13:0] tens_prod;
  logic [3:0]  tens_digit;
  logic [6:0]  tens_scaled;
  logic [3:0]  unit_digit;
  logic [3:0]  sel_digit;
  logic [1:0]  pos_eff;
  logic [1:0]  pos_prev;

  assign cmd_stall = skid_valid;
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign res_take  = res_valid && !res_stall;

  always_comb begin
    hund_prod   = 16'(count) * 16'(udscan_pkg::RecipHundred);
    hund_digit  = hund_prod[udscan_pkg::RecipHundredShift +: 4];
    hund_scaled = 10'(hund_digit) * 10'd100;
    rem_hund    = 7'(count - hund_scaled);
    tens_prod   = 14'(rem_hund) * 14'(udscan_pkg::RecipTen);
    tens_digit  = tens_prod[udscan_pkg::RecipTenShift +: 4];
    tens_scaled = 7'(tens_digit) * 7'd10;
    unit_digit  = 4'(rem_hund - tens_scaled);
  end

  always_comb begin
    // A scan position of 3 cannot arise; it is read as the hundreds digit.
    pos_eff  = (scan_pos == 2'd3) ? udscan_pkg::PosHundreds : scan_pos;
    pos_prev = (pos_eff == udscan_pkg::PosHundreds) ? udscan_pkg::PosUnits
                                                    : pos_eff - 2'd1;
    unique case (pos_eff)
      udscan_pkg::PosHundreds: sel_digit = hund_digit;
      udscan_pkg::PosTens:     sel_digit = tens_digit;
      default:                 sel_digit = unit_digit;
    endcase
  end

  always_comb begin
    count_next    = count;
    scan_pos_next = pos_eff;
    shown_next    = shown;
    enabled_next  = pos_prev;
    unique case (udscan_pkg::opcode_t'(opcode))
      udscan_pkg::OP_TICK: begin
        shown_next    = udscan_pkg::seg_decode(sel_digit);
        enabled_next  = pos_eff;
        scan_pos_next = (pos_eff == udscan_pkg::PosUnits) ? udscan_pkg::PosHundreds
                                                           : pos_eff + 2'd1;
      end
      udscan_pkg::OP_UP: begin
        if (count < udscan_pkg::CountMax) begin
          count_next = count + 10'd1;
        end
      end
      udscan_pkg::OP_DOWN: begin
        if (count != 10'd0) begin
          count_next = count - 10'd1;
        end
      end
      default: begin
        count_next = 10'(load_value);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      scan_pos   <= '0;
      shown      <= '0;
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (cmd_take) begin
        count    <= count_next;
        scan_pos <= scan_pos_next;
        shown    <= shown_next;
      end
      if (cmd_take && (!res_valid || res_take)) begin
        res_valid <= 1'b1;
      end else if (cmd_take) begin
        skid_valid <= 1'b1;
      end else if (res_take) begin
        res_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (cmd_take && (!res_valid || res_take)) begin
      segments    <= shown_next;
      digit_index <= enabled_next;
      count_value <= count_next;
    end else if (cmd_take) begin
      skid_segments    <= shown_next;
      skid_digit_index <= enabled_next;
      skid_count_value <= count_next;
    end else if (res_take && skid_valid) begin
      segments    <= skid_segments;
      digit_index <= skid_digit_index;
      count_value <= skid_count_value;
    end
  end

  `ASSERT_CLK(a_count_in_range, count <= udscan_pkg::CountMax, "count above 999")
  `ASSERT_CLK(a_scan_pos_in_range, scan_pos != 2'd3, "scan position out of range")
  `ASSERT_CLK(a_skid_needs_res, skid_valid |-> res_valid, "second slot full, first empty")
  `ASSERT_CLK(a_res_digit, res_valid |-> digit_index != 2'd3, "bad digit")
  `ASSERT_CLK(a_res_count, res_valid |-> count_value <= udscan_pkg::CountMax, "bad count")
  `ASSERT_CLK(a_skid_drains, (skid_valid && !res_stall) |=> !skid_valid, "slot stuck")

endmodule

FILE: bench/updown_counter_seven_segment_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// updown_counter_seven_segment_scan_checker
// Watches the request and result channels of the counter and scan core. It
// keeps its own copy of the count, the scan position and the latched
// pattern, predicts every result, and compares each one field by field.
// ----------------------------------------------------------------------------
module updown_counter_seven_segment_scan_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  logic       cmd_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] load_value,
  input  logic       res_valid,
  input  logic       res_stall,
  input  logic [6:0] segments,
  input  logic [1:0] digit_index,
  input  logic [9:0] count_value,
  output int         errors,
  output int         pending,
  output int         checked,
  output int         ceiling_hits,
  output int         floor_hits
);

  typedef struct packed {
    logic [udscan_pkg::SegW-1:0]   segments;
    logic [udscan_pkg::PosW-1:0]   digit;
    logic [udscan_pkg::CountW-1:0] count;
  } display_t;

  // Patterns for the digits 9 down to 0, so that index d selects digit d.
  localparam logic [9:0][udscan_pkg::SegW-1:0] Glyphs = {
    7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  logic [udscan_pkg::CountW-1:0] count_q;
  logic [udscan_pkg::PosW-1:0]   scan_q;
  logic [udscan_pkg::SegW-1:0]   shown_q;
  display_t                      display_q[$];

  function automatic logic [3:0] decimal_digit(input logic [udscan_pkg::CountW-1:0] value,
                                               input logic [udscan_pkg::PosW-1:0] pos);
    int unsigned v;
    v = value;
    case (pos)
      udscan_pkg::PosHundreds: return 4'(v / 100);
      udscan_pkg::PosTens:     return 4'((v / 10) % 10);
      default:                 return 4'(v % 10);
    endcase
  endfunction

  task automatic report(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic predict_display(input udscan_pkg::opcode_t op, input logic [7:0] load_byte);
    display_t want;
    logic [udscan_pkg::PosW-1:0] lit;
    if (scan_q > udscan_pkg::PosUnits) scan_q = udscan_pkg::PosHundreds;
    // Between ticks the enabled digit is the one just before the scan position.
    lit = (scan_q == udscan_pkg::PosHundreds) ? udscan_pkg::PosUnits : scan_q - 1'b1;
    case (op)
      udscan_pkg::OP_TICK: begin
        shown_q = Glyphs[decimal_digit(count_q, scan_q)];
        lit = scan_q;
        scan_q = (scan_q >= udscan_pkg::PosUnits) ? udscan_pkg::PosHundreds : scan_q + 1'b1;
      end
      udscan_pkg::OP_UP: begin
        if (count_q < udscan_pkg::CountMax) count_q = count_q + 1'b1;
        else ceiling_hits++;
      end
      udscan_pkg::OP_DOWN: begin
        if (count_q > 0) count_q = count_q - 1'b1;
        else floor_hits++;
      end
      default: begin
        count_q = {2'b00, load_byte};
      end
    endcase
    want.segments = shown_q;
    want.digit = lit;
    want.count = count_q;
    display_q.push_back(want);
  endtask

  task automatic compare_display();
    display_t want;
    if (display_q.size() == 0) begin
      report($sformatf("result with nothing expected (count %0d)", count_value));
    end else begin
      want = display_q.pop_front();
      if (segments !== want.segments)
        report($sformatf("segments got %b, expected %b (count %0d)",
                         segments, want.segments, want.count));
      if (digit_index !== want.digit)
        report($sformatf("digit_index got %0d, expected %0d", digit_index, want.digit));
      if (count_value !== want.count)
        report($sformatf("count_value got %0d, expected %0d", count_value, want.count));
      checked++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      count_q = '0;
      scan_q = udscan_pkg::PosHundreds;
      shown_q = '0;
      display_q.delete();
    end else begin
      if (res_valid && !res_stall) compare_display();
      if (cmd_valid && !cmd_stall) predict_display(udscan_pkg::opcode_t'(opcode), load_value);
    end
    pending = display_q.size();
  end

endmodule

FILE: bench/updown_counter_seven_segment_scan_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// updown_counter_seven_segment_scan_core_tb
// Drives the counter and scan core with a directed opening (blank display,
// saturation at zero, loads, scan wrap) and then random runs of ticks, up and
// down steps and loads, including one climb to the top of the range, under
// four flow-control phases. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module updown_counter_seven_segment_scan_core_tb;

  localparam int RandomItems = 1950;
  localparam int PhaseItems  = RandomItems / 4;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cmd_valid = 1'b0;
  logic [1:0] opcode = udscan_pkg::OP_TICK;
  logic [7:0] load_value = '0;
  logic       res_stall = 1'b0;
  logic       cmd_stall;
  logic       res_valid;
  logic [6:0] segments;
  logic [1:0] digit_index;
  logic [9:0] count_value;

  int errors, pending, checked, ceiling_hits, floor_hits;
  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;

  updown_counter_seven_segment_scan_core DUT (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .opcode      (opcode),
    .load_value  (load_value),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .segments    (segments),
    .digit_index (digit_index),
    .count_value (count_value)
  );

  updown_counter_seven_segment_scan_checker display_checker (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .opcode       (opcode),
    .load_value   (load_value),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .segments     (segments),
    .digit_index  (digit_index),
    .count_value  (count_value),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked),
    .ceiling_hits (ceiling_hits),
    .floor_hits   (floor_hits)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    res_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  initial begin
    #400_000;
    $display("Timeout: %0d results still expected", pending);
    $display("Test completed with failures");
    $finish;
  end

  // Holds the request until it is taken. Idle cycles before it carry noise.
  task automatic send(input udscan_pkg::opcode_t op, input logic [7:0] value);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      opcode <= 2'($urandom_range(3));
      load_value <= 8'($urandom_range(255));
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    opcode <= op;
    load_value <= value;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_op(input udscan_pkg::opcode_t op);
    send(op, 8'($urandom_range(255)));
  endtask

  task automatic scan_all();
    repeat (3) send_op(udscan_pkg::OP_TICK);
  endtask

  // Loads a high byte and steps up past 999, scanning the digits on the way.
  task automatic climb_to_top();
    int start;
    int steps;
    start = $urandom_range(200, 255);
    steps = 999 - start + $urandom_range(1, 6);
    send(udscan_pkg::OP_LOAD, 8'(start));
    for (int i = 0; i < steps; i++) begin
      send_op(udscan_pkg::OP_UP);
      if (i % 47 == 0) scan_all();
    end
    scan_all();
    send_op(udscan_pkg::OP_DOWN);
    send_op(udscan_pkg::OP_UP);
    send_op(udscan_pkg::OP_UP);
    scan_all();
  endtask

  task automatic random_run();
    int kind;
    int len;
    kind = $urandom_range(99);
    len = $urandom_range(1, 12);
    if (kind < 40) begin
      repeat (len) send_op(udscan_pkg::opcode_t'($urandom_range(3)));
    end else if (kind < 60) begin
      repeat ($urandom_range(1, 7)) send_op(udscan_pkg::OP_TICK);
    end else if (kind < 75) begin
      repeat ($urandom_range(1, 30))
        send_op(($urandom_range(4) == 0) ? udscan_pkg::OP_TICK : udscan_pkg::OP_UP);
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 30))
        send_op(($urandom_range(4) == 0) ? udscan_pkg::OP_TICK : udscan_pkg::OP_DOWN);
    end else begin
      send(udscan_pkg::OP_LOAD, 8'($urandom_range(255)));
      scan_all();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: blank display before any tick, the floor, byte
    // extremes and alternating bit patterns, and the scan wrapping around.
    send_op(udscan_pkg::OP_DOWN);
    send_op(udscan_pkg::OP_UP);
    send_op(udscan_pkg::OP_DOWN);
    send_op(udscan_pkg::OP_DOWN);
    send(udscan_pkg::OP_LOAD, 8'd255);
    scan_all();
    send_op(udscan_pkg::OP_TICK);
    send(udscan_pkg::OP_LOAD, 8'd0);
    send_op(udscan_pkg::OP_TICK);
    send_op(udscan_pkg::OP_TICK);
    send_op(udscan_pkg::OP_UP);
    send(udscan_pkg::OP_LOAD, 8'd128);
    send(udscan_pkg::OP_LOAD, 8'd127);
    send(udscan_pkg::OP_LOAD, 8'h55);
    send(udscan_pkg::OP_LOAD, 8'hAA);
    scan_all();
    send_op(udscan_pkg::OP_UP);
    send_op(udscan_pkg::OP_DOWN);
    send(udscan_pkg::OP_LOAD, 8'd9);
    scan_all();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 47; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 47; end
        default: begin idle_pct = 29; stall_pct <= 29; end
      endcase
      if (phase == 1) climb_to_top();
      while (sent < 25 + (phase + 1) * PhaseItems) random_run();
    end

    cmd_valid <= 1'b0;
    stall_pct <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);

    $display("%0d requests sent and %0d results checked over four flow-control phases.",
             sent, checked);
    $display("The count held at 999 on %0d up requests and at 0 on %0d down requests.",
             ceiling_hits, floor_hits);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/udscan_pkg.sv
hw/rtl/updown_counter_seven_segment_scan_core.sv
bench/updown_counter_seven_segment_scan_checker.sv
bench/updown_counter_seven_segment_scan_core_tb.sv
